FILE: src/cldpc_pkg.sv
// Shared types, code descriptors and generator ROM for the short-block LDPC encoder.
package cldpc_pkg;

  localparam int MAX_PARITY_BITS_DEF = 256;

  localparam logic [1:0] CODE_N128 = 2'd0;
  localparam logic [1:0] CODE_N256 = 2'd1;
  localparam logic [1:0] CODE_N512 = 2'd2;

  // register byte addresses
  localparam logic [1:0] ADDR_CODE_SELECT = 2'd0;

  // Base generator rows: n128 rows at words 0..7, n256 at 8..23, n512 at 24..55.
  localparam logic [31:0] GEN_ROM [56] = '{
    32'h0E69166B, 32'hEF4C0BC2, 32'h7766137E, 32'hBB248418,
    32'hC480FEB9, 32'hCD53A713, 32'h4EAA22FA, 32'h465EEA11,
    32'h73F5E839, 32'h0220CE51, 32'h36ED68E9, 32'hF39EB162,
    32'hBAC812C0, 32'hBCD24379, 32'h4786D928, 32'h5A09095C,
    32'h7DF83F76, 32'hA5FF4C38, 32'h8E6C0D4E, 32'h025EB712,
    32'hBAA37B32, 32'h60CB31C5, 32'hD0F66A31, 32'hFAF511BC,
    32'h1D21794A, 32'h22761FAE, 32'h59945014, 32'h257E130D,
    32'h74D60540, 32'h03794014, 32'h2DADEB9C, 32'hA25EF12E,
    32'h60E0B662, 32'h3C5CE512, 32'h4D2C81EC, 32'hC7F469AB,
    32'h20678DBF, 32'hB7523ECE, 32'h2B54B906, 32'hA9DBE98C,
    32'hF6739BCF, 32'h54273E77, 32'h167BDA12, 32'h0C6C4774,
    32'h4C071EFF, 32'h5E32A759, 32'h3138670C, 32'h095C39B5,
    32'h28706BD0, 32'h45300258, 32'h2DAB85F0, 32'h5B9201D0,
    32'h8DFDEE2D, 32'h9D84CA88, 32'hB371FAE6, 32'h3A4EB07E
  };

  typedef struct packed {
    logic absorb;
    logic shift;
    logic clear;
  } cell_ctrl_t;

  // log2 of bytes per circulant (circulant size M = k/4)
  function automatic logic [1:0] circ_lg(input logic [1:0] sel);
    logic [1:0] lg;
    unique case (sel)
      CODE_N128: lg = 2'd1;
      CODE_N256: lg = 2'd2;
      default:   lg = 2'd3;
    endcase
    return lg;
  endfunction

  // k/8, which equals r/8 for all three codes
  function automatic logic [5:0] block_bytes(input logic [1:0] sel);
    logic [5:0] n;
    unique case (sel)
      CODE_N128: n = 6'd8;
      CODE_N256: n = 6'd16;
      default:   n = 6'd32;
    endcase
    return n;
  endfunction

  function automatic logic [5:0] rom_base(input logic [1:0] sel);
    logic [5:0] w;
    unique case (sel)
      CODE_N128: w = 6'd0;
      CODE_N256: w = 6'd8;
      default:   w = 6'd24;
    endcase
    return w;
  endfunction

  // One byte of a base row, first column in the MSB.
  function automatic logic [7:0] rom_byte(input logic [1:0] sel, input logic [1:0] row,
                                          input logic [4:0] b);
    logic [5:0] word;
    word = rom_base(sel) + (6'(row) << circ_lg(sel)) + 6'(b >> 2);
    return 8'(GEN_ROM[word] >> {~b[1:0], 3'b000});
  endfunction

  // Generator window for parity byte p while absorbing data byte cnt.
  // Bits [15:8] are the byte's own columns, [7:0] the previous byte of the
  // same circulant (cyclically), column order ascending with bit index.
  function automatic logic [15:0] cell_window(input logic [1:0] sel, input logic [4:0] cnt,
                                              input logic [4:0] p);
    logic [1:0]  lg;
    logic [4:0]  nbm;
    logic [4:0]  s;
    logic [4:0]  i;
    logic [4:0]  qb;
    logic [4:0]  b_own;
    logic [4:0]  b_prv;
    logic [1:0]  row;
    logic [7:0]  own;
    logic [7:0]  prv;
    logic [15:0] w;
    lg    = circ_lg(sel);
    nbm   = (5'd1 << lg) - 5'd1;
    s     = cnt & nbm;
    row   = 2'(cnt >> lg);
    i     = p & nbm;
    qb    = p & ~nbm;
    b_own = qb | ((i - s) & nbm);
    b_prv = qb | ((i - s - 5'd1) & nbm);
    own   = rom_byte(sel, row, b_own);
    prv   = rom_byte(sel, row, b_prv);
    for (int e = 0; e < 8; e++) begin
      w[e]     = prv[7-e];
      w[8 + e] = own[7-e];
    end
    if ({1'b0, p} >= block_bytes(sel)) begin
      w = '0;
    end
    return w;
  endfunction

endpackage

FILE: src/cldpc_if.sv
// Request channel interfaces for data input and codeword output.
interface cldpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface cldpc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       is_parity;
  logic       last_of_block;

  modport source (output valid, output code_byte, output is_parity, output last_of_block,
                  input ready);
  modport sink (input valid, input code_byte, input is_parity, input last_of_block,
                output ready);
endinterface

FILE: src/cldpc_cell.sv
// One parity byte of the accumulator: absorbs a data byte, shifts toward the output.
module cldpc_cell #(
  parameter logic [7:0] KEEP = 8'hFF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cldpc_pkg::cell_ctrl_t  ctrl,
  input  logic [7:0]             data,
  input  logic [15:0]            win,
  input  logic [7:0]             nbr,
  output logic [7:0]             acc
);
  import cldpc_pkg::*;

  logic [7:0] acc_r;
  logic [7:0] acc_nxt;
  logic [7:0] mix;

  // column e (held in bit 7-e) takes window bit 8+e-b for data bit b (MSB first)
  always_comb begin
    mix = '0;
    for (int e = 0; e < 8; e++) begin
      for (int b = 0; b < 8; b++) begin
        mix[7-e] = mix[7-e] ^ (data[7-b] & win[8 + e - b]);
      end
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.clear) begin
      acc_nxt = '0;
    end else if (ctrl.shift) begin
      acc_nxt = nbr & KEEP;
    end else if (ctrl.absorb) begin
      acc_nxt = (acc_r ^ mix) & KEEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

FILE: src/ccsds_ldpc_systematic_encoder.sv
// Top level: code register, byte counter, generator lookup, cell chain and output register.
// Systematic encoder for the short LDPC codes n128/k64, n256/k128 and n512/k256, chosen by
// code_select (register 0; the value 3 selects n512). Data bytes are taken one per cycle unless
// the output or the parity drain holds them off and reach the output unchanged via s1; each
// byte's generator window is looked up from ROM in the accept cycle, held in s1 and XORed into
// a row of byte-wide accumulator cells as the byte enters the output register. After the k/8-th
// byte of a block the r/8 parity bytes (8, 16 or 32) shift out of the cell chain one per cycle
// while the output is not stalled, the last one marked; input is held off but for one byte in
// s1. The accumulator is cleared as the final parity byte leaves; no start-up pass is needed.
module ccsds_ldpc_systematic_encoder #(
  parameter int MAX_PARITY_BITS = cldpc_pkg::MAX_PARITY_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  cldpc_in_if.sink     in_ch,
  cldpc_out_if.source  out_ch,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [1:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import cldpc_pkg::*;

  localparam int NC = (MAX_PARITY_BITS + 7) / 8;

  logic [1:0]  code_sel_r;
  logic [1:0]  code_eff;
  logic [5:0]  kbytes;
  logic [4:0]  cnt_r;
  logic [5:0]  cnt_inc;
  logic        blk_end;

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic [7:0]  s1_mbyte_r;
  logic        s1_end_r;
  logic [15:0] s1_win_r [NC];

  logic        drain_r;
  logic [5:0]  dcnt_r;

  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_par_r;
  logic        out_last_r;

  logic        out_free;
  logic        s1_adv;
  logic        drain_pop;
  logic        in_ready;
  logic        in_fire;
  logic        cfg_wr;
  cell_ctrl_t  cctrl;
  logic [7:0]  acc [NC];

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == ADDR_CODE_SELECT);
  assign cfg_prdata = (cfg_paddr == ADDR_CODE_SELECT) ? {30'd0, code_sel_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_sel_r <= CODE_N256;
    end else if (cfg_wr) begin
      code_sel_r <= cfg_pwdata[1:0];
    end
  end

  assign code_eff = (code_sel_r == CODE_N128 || code_sel_r == CODE_N256) ? code_sel_r
                                                                         : CODE_N512;
  assign kbytes   = block_bytes(code_eff);

  // handshake
  assign out_free  = !out_valid_r || out_ch.ready;
  assign s1_adv    = s1_valid_r && !drain_r && out_free;
  assign drain_pop = drain_r && out_free;
  assign in_ready  = !s1_valid_r || s1_adv;
  assign in_fire   = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  assign cnt_inc = {1'b0, cnt_r} + 6'd1;
  assign blk_end = cnt_inc >= kbytes;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        cnt_r <= blk_end ? 5'd0 : cnt_inc[4:0];
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // bytes past the current k carry no parity
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r  <= in_ch.data_byte;
      s1_mbyte_r <= ({1'b0, cnt_r} < kbytes) ? in_ch.data_byte : 8'd0;
      s1_end_r   <= blk_end;
    end
  end

  // parity drain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drain_r <= 1'b0;
      dcnt_r  <= '0;
    end else if (s1_adv && s1_end_r) begin
      drain_r <= 1'b1;
      dcnt_r  <= kbytes;
    end else if (drain_pop) begin
      dcnt_r <= dcnt_r - 6'd1;
      if (dcnt_r == 6'd1) begin
        drain_r <= 1'b0;
      end
    end
  end

  assign cctrl.absorb = s1_adv;
  assign cctrl.shift  = drain_pop;
  assign cctrl.clear  = drain_pop && (dcnt_r == 6'd1);

  // cell chain; cell 0 feeds the output
  for (genvar g = 0; g < NC; g++) begin : g_cell
    localparam int KN = ((MAX_PARITY_BITS - 8 * g) >= 8) ? 8 : (MAX_PARITY_BITS - 8 * g);
    localparam logic [7:0] KEEP = 8'(8'hFF << (8 - KN));
    logic [7:0] nbr;

    always_ff @(posedge clk) begin
      if (in_fire) begin
        s1_win_r[g] <= cell_window(code_eff, cnt_r, 5'(g));
      end
    end

    if (g == NC - 1) begin : g_top
      assign nbr = 8'd0;
    end else begin : g_mid
      assign nbr = acc[g + 1];
    end

    cldpc_cell #(
      .KEEP(KEEP)
    ) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .ctrl (cctrl),
      .data (s1_mbyte_r),
      .win  (s1_win_r[g]),
      .nbr  (nbr),
      .acc  (acc[g])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv || drain_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_byte_r <= s1_byte_r;
      out_par_r  <= 1'b0;
      out_last_r <= 1'b0;
    end else if (drain_pop) begin
      out_byte_r <= acc[0];
      out_par_r  <= 1'b1;
      out_last_r <= (dcnt_r == 6'd1);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.code_byte     = out_byte_r;
  assign out_ch.is_parity     = out_par_r;
  assign out_ch.last_of_block = out_last_r;

endmodule

FILE: verif/cldpc_enc_checker.sv
// Scoreboard for the short-block LDPC encoder: follows the register port and both channels.
`timescale 1ns / 100ps
module cldpc_enc_checker #(
  parameter logic [1:0] CODE_SEL_ADDR = cldpc_pkg::ADDR_CODE_SELECT
) (
  input  logic        clk,
  input  logic        rst_n,
  cldpc_in_if         in_mon,
  cldpc_out_if        out_mon,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending,
  output int          blocks_seen
);
  import cldpc_pkg::*;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       is_parity;
    logic       last_of_block;
  } cw_byte_t;

  cw_byte_t     codeword_q[$];
  logic [1:0]   code_sel;
  logic [255:0] parity_acc;  // bit c is parity column c
  logic [5:0]   byte_cnt;
  int           n_fail = 0;
  int           n_blocks = 0;
  int           n_pending = 0;

  assign fail_count  = n_fail;
  assign pending     = n_pending;
  assign blocks_seen = n_blocks;

  // k, which equals r for all three codes; the unused selector acts as n512
  function automatic int unsigned info_bits(input logic [1:0] sel);
    case (sel)
      CODE_N128: return 64;
      CODE_N256: return 128;
      default:   return 256;
    endcase
  endfunction

  function automatic logic gen_bit(input logic [1:0] sel, input int unsigned row,
                                   input int unsigned col);
    int unsigned word0;
    int unsigned word;
    case (sel)
      CODE_N128: word0 = 0;
      CODE_N256: word0 = 8;
      default:   word0 = 24;
    endcase
    word = word0 + row * (info_bits(sel) / 32) + col / 32;
    if (word >= $size(GEN_ROM)) return 1'b0;
    return GEN_ROM[word][31 - col % 32];
  endfunction

  // XOR generator row j into the accumulator; each circulant rotated right by j mod M
  task automatic absorb_info_bit(input int unsigned j);
    int unsigned r;
    int unsigned m;
    int unsigned row;
    int unsigned t;
    int unsigned src;
    r   = info_bits(code_sel);
    m   = r / 4;
    row = j / m;
    t   = j % m;
    for (int unsigned c = 0; c < r; c++) begin
      src = (c / m) * m + (c % m + m - t) % m;
      if (gen_bit(code_sel, row, src)) parity_acc[c] = ~parity_acc[c];
    end
  endtask

  task automatic encode_byte(input logic [7:0] data);
    int unsigned kb;
    int unsigned j;
    logic [7:0]  pb;
    kb = info_bits(code_sel);
    codeword_q.push_back('{data, 1'b0, 1'b0});
    for (int b = 0; b < 8; b++) begin
      j = byte_cnt * 8 + b;
      // bits past k are dropped after a switch to a shorter code
      if (data[7-b] && j < kb) absorb_info_bit(j);
    end
    byte_cnt = byte_cnt + 6'd1;
    if (byte_cnt >= kb / 8) begin
      for (int p = 0; p < kb / 8; p++) begin
        for (int e = 0; e < 8; e++) pb[7-e] = parity_acc[8*p + e];
        codeword_q.push_back('{pb, 1'b1, (p == kb / 8 - 1)});
      end
      parity_acc = '0;
      byte_cnt   = '0;
    end
  endtask

  task automatic note_failure(input string what, input cw_byte_t want, input cw_byte_t got);
    n_fail++;
    if (n_fail <= 10) begin
      $display("%0t ERROR %s: expected byte %h parity %b last %b, got byte %h parity %b last %b",
               $realtime, what, want.code_byte, want.is_parity, want.last_of_block,
               got.code_byte, got.is_parity, got.last_of_block);
    end
  endtask

  always @(posedge clk) begin
    cw_byte_t want;
    cw_byte_t got;
    if (!rst_n) begin
      code_sel   = CODE_N256;
      parity_acc = '0;
      byte_cnt   = '0;
      codeword_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == CODE_SEL_ADDR)
        code_sel = cfg_pwdata[1:0];
      if (in_mon.valid && in_mon.ready) encode_byte(in_mon.data_byte);
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.code_byte, out_mon.is_parity, out_mon.last_of_block};
        if (codeword_q.size() == 0) begin
          note_failure("unexpected output byte", '0, got);
        end else begin
          want = codeword_q.pop_front();
          if (want != got) note_failure("output byte mismatch", want, got);
          if (got.last_of_block) n_blocks++;
        end
      end
    end
    n_pending = codeword_q.size();
  end

endmodule

FILE: verif/tb_ccsds_ldpc_systematic_encoder.sv
// Testbench top for the short-block LDPC encoder: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_ccsds_ldpc_systematic_encoder;
  import cldpc_pkg::*;

  localparam logic [1:0] CODE_SEL_ADDR = ADDR_CODE_SELECT;
  localparam logic [1:0] CODE_SPARE    = 2'd3;
  localparam int         HOLD_CYCLES   = 120;
  localparam int         RANDOM_ITEMS  = 250;
  localparam int         TOTAL_ITEMS   = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [1:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  cldpc_in_if  in_ch ();
  cldpc_out_if out_ch ();

  int         n_fail;
  int         n_pending;
  int         n_blocks;
  int         n_sent = 0;
  int         blk_pos = 0;  // bytes taken in the current block, as the encoder counts them
  logic [1:0] cur_code = CODE_N256;
  bit         src_idle_on = 1'b0;
  bit         sink_idle_on = 1'b0;
  bit         hold_req = 1'b0;

  ccsds_ldpc_systematic_encoder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  cldpc_enc_checker #(.CODE_SEL_ADDR(CODE_SEL_ADDR)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .fail_count  (n_fail),
    .pending     (n_pending),
    .blocks_seen (n_blocks)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int info_bytes(input logic [1:0] code);
    case (code)
      CODE_N128: return 8;
      CODE_N256: return 16;
      default:   return 32;
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h01 << $urandom_range(0, 7);
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic logic [1:0] pick_code();
    case ($urandom_range(0, 6))
      0, 1:    return CODE_N128;
      2, 3:    return CODE_N256;
      4, 5:    return CODE_N512;
      default: return CODE_SPARE;
    endcase
  endfunction

  // bytes until the current block closes under the current code
  function automatic int bytes_to_end();
    return (blk_pos >= info_bytes(cur_code)) ? 1 : info_bytes(cur_code) - blk_pos;
  endfunction

  // called at a falling edge; valid stays high on return so back-to-back requests need no gap
  task automatic send_byte(input logic [7:0] data);
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.data_byte = data;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    n_sent++;
    blk_pos++;
    if (blk_pos >= info_bytes(cur_code)) blk_pos = 0;
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_byte(pick_byte());
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_code(input logic [1:0] code);
    logic [31:0] wdata;
    wdata       = $urandom();
    wdata[1:0]  = code;
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = CODE_SEL_ADDR;
    cfg_pwdata  = wdata;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cur_code    = code;
  endtask

  // output side: short random stalls, or one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end
      out_ch.ready = 1'b1;
    end
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [7:0] reset_code_bytes[2] = '{8'hFF, 8'h80};
    logic [7:0] switch_bytes[6]     = '{8'h00, 8'h01, 8'hFF, 8'h7F, 8'hFE, 8'hFF};
    logic [7:0] edge_bytes[8]       = '{8'h00, 8'hFF, 8'hAA, 8'h55, 8'h80, 8'h01, 8'hFF, 8'h00};
    int nblk;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset selection (n256), then drop to n128 part way into the block
    foreach (reset_code_bytes[i]) send_byte(reset_code_bytes[i]);
    drain();
    set_code(CODE_N128);
    foreach (switch_bytes[i]) send_byte(switch_bytes[i]);
    foreach (edge_bytes[i]) send_byte(edge_bytes[i]);
    // unused selector acts as n512; the switch back leaves the count at k/8,
    // so the next byte closes the block and its bits fall outside k
    drain();
    set_code(CODE_SPARE);
    repeat (8) send_byte(8'hFF);
    drain();
    set_code(CODE_N128);
    send_byte(8'hFF);

    // long output hold-off while input keeps coming: encoder must back up
    drain();
    set_code(CODE_N512);
    src_idle_on = 1'b0;
    hold_req    = 1'b1;
    send_random(bytes_to_end() + 8);

    while (n_sent < RANDOM_ITEMS) begin
      drain();
      set_code(pick_code());
      src_idle_on  = ($urandom_range(0, 3) != 0);
      sink_idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) == 0) begin
        // leave a partial block so the next phase switches code mid-block
        send_random($urandom_range(1, info_bytes(cur_code) - 1));
      end else begin
        nblk = (cur_code == CODE_N128) ? $urandom_range(1, 3) : $urandom_range(1, 2);
        send_random(bytes_to_end() + (nblk - 1) * info_bytes(cur_code));
      end
    end

    // closing stretch at full rate on both sides
    drain();
    set_code(pick_code());
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    while (n_sent < TOTAL_ITEMS || blk_pos != 0) send_byte(pick_byte());
    in_ch.valid = 1'b0;

    while (n_pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("summary: %0d data bytes in, %0d codewords checked", n_sent, n_blocks);
    $display("summary: all four selector values, mid-block switches, long output hold-off");
    if (n_fail == 0 && n_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
